[hdl/sapq_pkg.sv]
package sapq_pkg;

    // payload widths
    localparam int KEY_W    = 16;
    localparam int TAG_W    = 10;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // request kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic update;
    } t_cmd;

endpackage

[hdl/sapq_in_if.sv]
interface sapq_in_if;

    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [sapq_pkg::KEY_W-1:0] key;
    logic [sapq_pkg::TAG_W-1:0] tag;

    modport source (output valid, output kind, output key, output tag, input ready);
    modport sink   (input valid, input kind, input key, input tag, output ready);

endinterface

[hdl/sapq_out_if.sv]
interface sapq_out_if;

    logic                          valid;
    logic                          ready;
    logic [sapq_pkg::STATUS_W-1:0] status;
    logic [sapq_pkg::KEY_W-1:0]    out_key;
    logic [sapq_pkg::TAG_W-1:0]    out_tag;
    logic [sapq_pkg::FILL_W-1:0]   fill;

    modport source (output valid, output status, output out_key, output out_tag,
                    output fill, input ready);
    modport sink   (input valid, input status, input out_key, input out_tag,
                    input fill, output ready);

endinterface

[hdl/sorted_array_priority_queue.sv]
// Bounded min-priority queue held as a sorted row of DEPTH slots.
// Request channel i_req: kind 0 inserts (key, tag) ahead of the first stored
// entry whose key is greater or equal, so the newest of equal keys leaves
// first; kind 1 pops the entry with the smallest key.
// Response channel o_rsp: one response per request with status (done,
// overflow on insert when full, empty on pop when empty), the popped key and
// tag (zero otherwise) and the fill level after the request.
// Each request is captured, compared against all slots in parallel, then
// applied by shifting the row and writing the response register; a new
// request is accepted only after the previous one has left its update step.
// The response register frees the request side: a new request is accepted
// while the previous response still waits. If the receiver stalls, the next
// request waits in its update step until the pending response is taken.
// Reset (synchronous, active low) empties the queue and drops any pending
// response; slot contents are not cleared.
module sorted_array_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sapq_in_if.sink     i_req,
    sapq_out_if.source  o_rsp
);

    sapq_pkg::t_cmd cmd;

    sapq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    sapq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_kind    (i_req.kind),
        .i_key     (i_req.key),
        .i_tag     (i_req.tag),
        .o_status  (o_rsp.status),
        .o_out_key (o_rsp.out_key),
        .o_out_tag (o_rsp.out_tag),
        .o_fill    (o_rsp.fill)
    );

`ifndef NO_ASSERTIONS
    // an accepted request is compared in the following cycle
    a_accept_then_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> cmd.compare)
        else $error("accepted request not followed by compare");

    // no new request while compare result is being applied
    a_cmp_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.compare |=> !i_req.ready)
        else $error("request accepted during update step");

    // update never overwrites a response that is not being taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.update |-> (!o_rsp.valid || o_rsp.ready))
        else $error("pending response overwritten");

    // every update presents a response
    a_update_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.update |=> o_rsp.valid)
        else $error("update without response");
`endif

endmodule

[hdl/sapq_ctrl.sv]
module sapq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sapq_pkg::t_cmd o_cmd
);

    sapq_pkg::t_state r_state;
    sapq_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             upd_go;

    // update may run once the response register is free or being drained
    assign upd_go = (r_state == sapq_pkg::S_UPD) && (!r_out_valid || i_out_ready);

    // handshake and commands
    assign o_in_ready    = (r_state == sapq_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.load    = i_in_valid && o_in_ready;
    assign o_cmd.compare = (r_state == sapq_pkg::S_CMP);
    assign o_cmd.update  = upd_go;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sapq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = sapq_pkg::S_CMP;
                end
            end
            sapq_pkg::S_CMP: begin
                n_state = sapq_pkg::S_UPD;
            end
            sapq_pkg::S_UPD: begin
                if (upd_go) begin
                    n_state = sapq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sapq_pkg::S_IDLE;
            end
        endcase
    end

    // response valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (upd_go) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sapq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hdl/sapq_dp.sv]
module sapq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sapq_pkg::t_cmd                i_cmd,
    input  logic                          i_kind,
    input  logic [sapq_pkg::KEY_W-1:0]    i_key,
    input  logic [sapq_pkg::TAG_W-1:0]    i_tag,
    output logic [sapq_pkg::STATUS_W-1:0] o_status,
    output logic [sapq_pkg::KEY_W-1:0]    o_out_key,
    output logic [sapq_pkg::TAG_W-1:0]    o_out_tag,
    output logic [sapq_pkg::FILL_W-1:0]   o_fill
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // sorted entry row, slot 0 holds the smallest key
    logic [sapq_pkg::KEY_W-1:0] r_key_a [DEPTH];
    logic [sapq_pkg::TAG_W-1:0] r_tag_a [DEPTH];
    logic [sapq_pkg::KEY_W-1:0] n_key_a [DEPTH];
    logic [sapq_pkg::TAG_W-1:0] n_tag_a [DEPTH];
    logic [CNT_W-1:0]           r_occ;
    logic [CNT_W-1:0]           n_occ;

    // captured request
    logic                       r_kind;
    logic [sapq_pkg::KEY_W-1:0] r_in_key;
    logic [sapq_pkg::TAG_W-1:0] r_in_tag;

    // per slot: at or behind the insertion point
    logic [DEPTH-1:0]           r_at;
    logic [DEPTH-1:0]           n_at;

    // response register
    sapq_pkg::t_status          r_status;
    sapq_pkg::t_status          n_status;
    logic [sapq_pkg::KEY_W-1:0] r_out_key;
    logic [sapq_pkg::KEY_W-1:0] n_out_key;
    logic [sapq_pkg::TAG_W-1:0] r_out_tag;
    logic [sapq_pkg::TAG_W-1:0] n_out_tag;
    logic [sapq_pkg::FILL_W-1:0] r_fill;

    logic full;
    logic empty;
    logic do_ins;
    logic do_pop;

    assign full   = (r_occ == CNT_W'(DEPTH));
    assign empty  = (r_occ == '0);
    assign do_ins = i_cmd.update && (r_kind == sapq_pkg::KIND_INSERT) && !full;
    assign do_pop = i_cmd.update && (r_kind == sapq_pkg::KIND_POP) && !empty;

    // parallel compare of every slot against the new key
    always_comb begin
        for (int j = 0; j < DEPTH; j++) begin
            n_at[j] = (CNT_W'(j) >= r_occ) || (r_in_key <= r_key_a[j]);
        end
    end

    // slot cells: hold, take the new entry, or take a neighbor
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic prev_at;
            if (g == 0) begin : g_head
                assign prev_at = 1'b0;
            end else begin : g_body
                assign prev_at = r_at[g-1];
            end

            always_comb begin
                n_key_a[g] = r_key_a[g];
                n_tag_a[g] = r_tag_a[g];
                if (do_pop) begin
                    if (g < DEPTH - 1) begin
                        n_key_a[g] = r_key_a[(g + 1) % DEPTH];
                        n_tag_a[g] = r_tag_a[(g + 1) % DEPTH];
                    end
                end else if (do_ins) begin
                    if (prev_at) begin
                        n_key_a[g] = r_key_a[(g + DEPTH - 1) % DEPTH];
                        n_tag_a[g] = r_tag_a[(g + DEPTH - 1) % DEPTH];
                    end else if (r_at[g]) begin
                        n_key_a[g] = r_in_key;
                        n_tag_a[g] = r_in_tag;
                    end
                end
            end
        end
    endgenerate

    // occupancy and response
    always_comb begin
        n_occ     = r_occ;
        n_status  = sapq_pkg::ST_DONE;
        n_out_key = '0;
        n_out_tag = '0;
        if (r_kind == sapq_pkg::KIND_POP) begin
            if (empty) begin
                n_status = sapq_pkg::ST_EMPTY;
            end else begin
                n_out_key = r_key_a[0];
                n_out_tag = r_tag_a[0];
                n_occ     = r_occ - CNT_W'(1);
            end
        end else begin
            if (full) begin
                n_status = sapq_pkg::ST_OVERFLOW;
            end else begin
                n_occ = r_occ + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.update) begin
            r_occ <= n_occ;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_in_key <= i_key;
            r_in_tag <= i_tag;
        end
        if (i_cmd.compare) begin
            r_at <= n_at;
        end
        for (int j = 0; j < DEPTH; j++) begin
            r_key_a[j] <= n_key_a[j];
            r_tag_a[j] <= n_tag_a[j];
        end
        if (i_cmd.update) begin
            r_status  <= n_status;
            r_out_key <= n_out_key;
            r_out_tag <= n_out_tag;
            r_fill    <= sapq_pkg::FILL_W'(n_occ);
        end
    end

    assign o_status  = r_status;
    assign o_out_key = r_out_key;
    assign o_out_tag = r_out_tag;
    assign o_fill    = r_fill;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int QUEUE_DEPTH   = 16;
    localparam int RANDOM_COUNT  = 500;
    // no idling once this few requests remain to be sent
    localparam int TAIL_REQUESTS = 40;
    // requests taken before the receiver holds off for a long stretch
    localparam int HOLD_TRIGGER  = 150;
    localparam int HOLD_CYCLES   = 60;
    localparam int STUCK_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = 10;

    typedef struct packed {
        logic                       kind;
        logic [sapq_pkg::KEY_W-1:0] key;
        logic [sapq_pkg::TAG_W-1:0] tag;
    } t_pq_request;

    typedef struct packed {
        sapq_pkg::t_status           status;
        logic [sapq_pkg::KEY_W-1:0]  out_key;
        logic [sapq_pkg::TAG_W-1:0]  out_tag;
        logic [sapq_pkg::FILL_W-1:0] fill;
    } t_pq_response;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sapq_in_if  req_if ();
    sapq_out_if rsp_if ();

    sorted_array_priority_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // stimulus backlog and expected responses
    t_pq_request  request_backlog [$];
    t_pq_response pending_responses [$];

    // shadow copy of the sorted slots
    logic [sapq_pkg::KEY_W-1:0] shadow_key [QUEUE_DEPTH];
    logic [sapq_pkg::TAG_W-1:0] shadow_tag [QUEUE_DEPTH];
    int                         shadow_fill = 0;

    int   mismatches     = 0;
    int   requests_taken = 0;
    int   send_gap       = 0;
    int   recv_gap       = 0;
    logic quiet_tail     = 1'b0;
    logic hold_active    = 1'b0;
    logic hold_done      = 1'b0;
    int   hold_count     = 0;
    int   stuck_cycles   = 0;

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // apply one request to the shadow queue and return its response
    function automatic t_pq_response sorted_queue_step(
        input logic                       kind,
        input logic [sapq_pkg::KEY_W-1:0] key,
        input logic [sapq_pkg::TAG_W-1:0] tag);
        t_pq_response rsp;
        int           pos;
        logic         found;
        rsp = '{status: sapq_pkg::ST_DONE, out_key: '0, out_tag: '0, fill: '0};
        if (kind == sapq_pkg::KIND_POP) begin
            if (shadow_fill == 0) begin
                rsp.status = sapq_pkg::ST_EMPTY;
            end else begin
                rsp.out_key = shadow_key[0];
                rsp.out_tag = shadow_tag[0];
                for (int j = 1; j < shadow_fill; j++) begin
                    shadow_key[j-1] = shadow_key[j];
                    shadow_tag[j-1] = shadow_tag[j];
                end
                shadow_fill--;
            end
        end else begin
            if (shadow_fill >= QUEUE_DEPTH) begin
                rsp.status = sapq_pkg::ST_OVERFLOW;
            end else begin
                // first slot whose key is greater or equal takes the new entry
                pos   = shadow_fill;
                found = 1'b0;
                for (int j = 0; j < shadow_fill; j++) begin
                    if (!found && key <= shadow_key[j]) begin
                        pos   = j;
                        found = 1'b1;
                    end
                end
                for (int j = shadow_fill; j > pos; j--) begin
                    shadow_key[j] = shadow_key[j-1];
                    shadow_tag[j] = shadow_tag[j-1];
                end
                shadow_key[pos] = key;
                shadow_tag[pos] = tag;
                shadow_fill++;
            end
        end
        rsp.fill = sapq_pkg::FILL_W'(shadow_fill);
        return rsp;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatches++;
        end
    endtask

    task automatic add_request(input logic kind, input logic [sapq_pkg::KEY_W-1:0] key,
                               input logic [sapq_pkg::TAG_W-1:0] tag);
        request_backlog.push_back('{kind: kind, key: key, tag: tag});
    endtask

    // request driver
    always @(posedge clk) begin
        if (rst_n) begin
            quiet_tail <= (request_backlog.size() < TAIL_REQUESTS);
            if (!req_if.valid || req_if.ready) begin
                if (send_gap > 0) begin
                    send_gap     <= send_gap - 1;
                    req_if.valid <= 1'b0;
                end else if (request_backlog.size() > 0) begin
                    req_if.kind  <= request_backlog[0].kind;
                    req_if.key   <= request_backlog[0].key;
                    req_if.tag   <= request_backlog[0].tag;
                    req_if.valid <= 1'b1;
                    void'(request_backlog.pop_front());
                    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                        send_gap <= $urandom_range(1, 7);
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once, so the block fills and stalls its input
    always @(posedge clk) begin
        if (rst_n) begin
            if (!hold_active && !hold_done && requests_taken >= HOLD_TRIGGER) begin
                hold_active <= 1'b1;
                hold_count  <= 0;
            end else if (hold_active) begin
                if (hold_count == HOLD_CYCLES) begin
                    hold_active <= 1'b0;
                    hold_done   <= 1'b1;
                end else begin
                    hold_count <= hold_count + 1;
                end
            end
        end
    end

    // response monitor: checks responses, predicts accepted requests, drives ready
    always @(posedge clk) begin : rsp_monitor
        t_pq_response want;
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_responses.size() == 0) begin
                    $display({"%0t: response with nothing expected, ",
                              "actual status %0d key %0h tag %0h fill %0d"},
                             $time, rsp_if.status, rsp_if.out_key, rsp_if.out_tag,
                             rsp_if.fill);
                    mismatches++;
                end else begin
                    want = pending_responses.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp_if.status));
                    check_field("out_key", 32'(want.out_key), 32'(rsp_if.out_key));
                    check_field("out_tag", 32'(want.out_tag), 32'(rsp_if.out_tag));
                    check_field("fill", 32'(want.fill), 32'(rsp_if.fill));
                end
            end
            if (req_if.valid && req_if.ready) begin
                pending_responses.push_back(sorted_queue_step(req_if.kind, req_if.key,
                                                              req_if.tag));
                requests_taken <= requests_taken + 1;
            end
            // receiver stalls in random bursts
            if (hold_active) begin
                rsp_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap     <= recv_gap - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                    recv_gap <= $urandom_range(1, 7);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int                         made;
        int                         mode;
        int                         run_len;
        int                         insert_pct;
        logic [sapq_pkg::KEY_W-1:0] key;

        req_if.valid = 1'b0;
        req_if.kind  = sapq_pkg::KIND_INSERT;
        req_if.key   = '0;
        req_if.tag   = '0;
        rsp_if.ready = 1'b0;

        // directed: pop when empty, extremes, equal keys, fill to overflow, five pops
        add_request(sapq_pkg::KIND_POP, 16'hFFFF, 10'h3FF);
        add_request(sapq_pkg::KIND_INSERT, 16'h8000, 10'h001);
        add_request(sapq_pkg::KIND_INSERT, 16'h8000, 10'h002);
        add_request(sapq_pkg::KIND_INSERT, 16'h0000, 10'h000);
        add_request(sapq_pkg::KIND_INSERT, 16'hFFFF, 10'h3FF);
        add_request(sapq_pkg::KIND_INSERT, 16'hFFFF, 10'h155);
        add_request(sapq_pkg::KIND_INSERT, 16'h1234, 10'h2AA);
        for (int i = 0; i < 10; i++) begin
            add_request(sapq_pkg::KIND_INSERT,
                        16'h5555 ^ sapq_pkg::KEY_W'(i * 16'h1111),
                        sapq_pkg::TAG_W'(10'h200 + i));
        end
        add_request(sapq_pkg::KIND_INSERT, 16'h0001, 10'h3FF);
        add_request(sapq_pkg::KIND_INSERT, 16'hFFFF, 10'h000);
        for (int i = 0; i < 5; i++) begin
            add_request(sapq_pkg::KIND_POP, sapq_pkg::KEY_W'($urandom),
                        sapq_pkg::TAG_W'($urandom));
        end

        // random runs that push toward full, toward empty, or stay mixed
        made = 0;
        while (made < RANDOM_COUNT) begin
            mode    = $urandom_range(0, 2);
            run_len = $urandom_range(8, 40);
            case (mode)
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 50;
            endcase
            for (int i = 0; i < run_len; i++) begin
                case ($urandom_range(0, 3))
                    0:       key = sapq_pkg::KEY_W'($urandom_range(0, 7));
                    1:       key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: key = sapq_pkg::KEY_W'($urandom);
                endcase
                if ($urandom_range(0, 99) < insert_pct) begin
                    add_request(sapq_pkg::KIND_INSERT, key, sapq_pkg::TAG_W'($urandom));
                end else begin
                    add_request(sapq_pkg::KIND_POP, key, sapq_pkg::TAG_W'($urandom));
                end
                made++;
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // wait until every request is sent and every response is in
        do begin
            @(posedge clk);
        end while (request_backlog.size() != 0 || req_if.valid ||
                   pending_responses.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
